FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/wcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types and codes of the wash-cycle sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

    // Field widths
    localparam int CFG_W     = 24;
    localparam int OP_W      = 3;
    localparam int PH_W      = 4;
    localparam int CFG_IDX_W = 3;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_START      = 3'd1;
    localparam logic [OP_W-1:0] OP_PAUSE      = 3'd2;
    localparam logic [OP_W-1:0] OP_RESUME     = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET_DONE = 3'd4;

    // Phase codes
    localparam logic [PH_W-1:0] PH_WAIT    = 4'd0;
    localparam logic [PH_W-1:0] PH_FILL    = 4'd1;
    localparam logic [PH_W-1:0] PH_PAUSED  = 4'd2;
    localparam logic [PH_W-1:0] PH_SETTLE  = 4'd3;
    localparam logic [PH_W-1:0] PH_CLEAN   = 4'd4;
    localparam logic [PH_W-1:0] PH_DRAIN   = 4'd5;
    localparam logic [PH_W-1:0] PH_PURGE   = 4'd6;
    localparam logic [PH_W-1:0] PH_SETTLE2 = 4'd7;
    localparam logic [PH_W-1:0] PH_FINAL   = 4'd8;
    localparam logic [PH_W-1:0] PH_DONE    = 4'd9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MILK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PURGE  = 3'd4;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_SETTLE = 24'd2000;
    localparam logic [CFG_W-1:0] RST_MILK   = 24'd5000;
    localparam logic [CFG_W-1:0] RST_CLEAN  = 24'd600000;
    localparam logic [CFG_W-1:0] RST_DRAIN  = 24'd60000;
    localparam logic [CFG_W-1:0] RST_PURGE  = 24'd30000;

    // Latched actuator commands
    typedef struct packed {
        logic divert;
        logic hot;
        logic cold;
        logic milk;
        logic vacuum;
    } t_act;

    // Timing configuration
    typedef struct packed {
        logic [CFG_W-1:0] settle_delay_ms;
        logic [CFG_W-1:0] milk_pump_delay_ms;
        logic [CFG_W-1:0] clean_time_ms;
        logic [CFG_W-1:0] drain_time_ms;
        logic [CFG_W-1:0] purge_time_ms;
    } t_cfg;

endpackage

FILE: rtl/wcs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_step
// Next-state logic: applies one tick or command to the sequencer state.
// ----------------------------------------------------------------------------
module wcs_step #(
    parameter int TIMER_BITS = 24
) (
    input  logic [wcs_pkg::OP_W-1:0] i_opcode,
    input  logic                     i_cold_mode,
    input  logic                     i_level_reached,
    input  wcs_pkg::t_cfg            i_cfg,
    input  logic [wcs_pkg::PH_W-1:0] i_phase,
    input  logic [TIMER_BITS-1:0]    i_elapsed,
    input  logic                     i_cold_choice,
    input  wcs_pkg::t_act            i_act,
    output logic [wcs_pkg::PH_W-1:0] o_phase,
    output logic [TIMER_BITS-1:0]    o_elapsed,
    output logic                     o_cold_choice,
    output wcs_pkg::t_act            o_act
);
    import wcs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      el_w;
    logic                  gt_settle;
    logic                  gt_milk;
    logic                  gt_clean;
    logic                  gt_drain;
    logic                  gt_purge;

    // Saturating elapsed count, then the phase-time compares
    assign elapsed_inc = (i_elapsed == {TIMER_BITS{1'b1}}) ? i_elapsed
                                                           : i_elapsed + TIMER_BITS'(1);
    assign el_w      = CMP_W'(elapsed_inc);
    assign gt_settle = el_w > CMP_W'(i_cfg.settle_delay_ms);
    assign gt_milk   = el_w > CMP_W'(i_cfg.milk_pump_delay_ms);
    assign gt_clean  = el_w > CMP_W'(i_cfg.clean_time_ms);
    assign gt_drain  = el_w > CMP_W'(i_cfg.drain_time_ms);
    assign gt_purge  = el_w > CMP_W'(i_cfg.purge_time_ms);

    // Phase update
    always_comb begin
        o_phase       = i_phase;
        o_elapsed     = i_elapsed;
        o_cold_choice = i_cold_choice;
        o_act         = i_act;
        case (i_opcode)
            OP_TICK: begin
                o_elapsed = elapsed_inc;
                case (i_phase)
                    PH_FILL: begin
                        o_act.divert = 1'b1;
                        if (i_cold_choice) begin
                            o_act.cold = 1'b1;
                        end else begin
                            o_act.hot = 1'b1;
                        end
                        if (i_level_reached) begin
                            o_act.cold = 1'b0;
                            o_act.hot  = 1'b0;
                            o_elapsed  = '0;
                            o_phase    = PH_SETTLE;
                        end
                    end
                    PH_PAUSED: begin
                        o_act.cold = 1'b0;
                        o_act.hot  = 1'b0;
                    end
                    PH_SETTLE: begin
                        if (gt_settle) begin
                            o_elapsed = '0;
                            o_phase   = PH_CLEAN;
                        end
                    end
                    PH_CLEAN: begin
                        o_act.vacuum = 1'b1;
                        if (gt_milk) begin
                            o_act.milk = 1'b1;
                        end
                        if (gt_clean) begin
                            o_elapsed = '0;
                            o_phase   = PH_DRAIN;
                        end
                    end
                    PH_DRAIN: begin
                        o_act.milk   = 1'b0;
                        o_act.divert = 1'b0;
                        if (gt_drain) begin
                            o_elapsed = '0;
                            o_phase   = PH_PURGE;
                        end
                    end
                    PH_PURGE: begin
                        o_act.milk = 1'b1;
                        if (gt_purge) begin
                            o_act.milk = 1'b0;
                            o_elapsed  = '0;
                            o_phase    = PH_SETTLE2;
                        end
                    end
                    PH_SETTLE2: begin
                        if (gt_settle) begin
                            o_act.vacuum = 1'b0;
                            o_elapsed    = '0;
                            o_phase      = PH_FINAL;
                        end
                    end
                    PH_FINAL: begin
                        if (gt_settle) begin
                            o_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START: begin
                o_cold_choice = i_cold_mode;
                o_phase       = PH_FILL;
            end
            OP_PAUSE: begin
                if (i_phase == PH_FILL) begin
                    o_phase = PH_PAUSED;
                end
            end
            OP_RESUME: begin
                if (i_phase == PH_PAUSED) begin
                    o_phase = PH_FILL;
                end
            end
            OP_RESET_DONE: begin
                if (i_phase == PH_DONE) begin
                    o_phase = PH_WAIT;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/wcs_remain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_remain
// Time left in the clean, drain or purge phase, saturated at zero.
// ----------------------------------------------------------------------------
module wcs_remain #(
    parameter int TIMER_BITS = 24
) (
    input  logic [wcs_pkg::PH_W-1:0]  i_phase,
    input  logic [TIMER_BITS-1:0]     i_elapsed,
    input  wcs_pkg::t_cfg             i_cfg,
    output logic [wcs_pkg::CFG_W-1:0] o_remaining
);
    import wcs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic             timed;
    logic [CFG_W-1:0] limit;
    logic [CMP_W-1:0] lim_w;
    logic [CMP_W-1:0] el_w;
    logic [CMP_W-1:0] diff;

    // Pick the limit of the timed phase
    always_comb begin
        timed = 1'b1;
        limit = i_cfg.clean_time_ms;
        case (i_phase)
            PH_CLEAN: limit = i_cfg.clean_time_ms;
            PH_DRAIN: limit = i_cfg.drain_time_ms;
            PH_PURGE: limit = i_cfg.purge_time_ms;
            default:  timed = 1'b0;
        endcase
    end

    // Limit minus elapsed, zero once elapsed has caught up
    assign lim_w       = CMP_W'(limit);
    assign el_w        = CMP_W'(i_elapsed);
    assign diff        = lim_w - el_w;
    assign o_remaining = (timed && (el_w < lim_w)) ? diff[CFG_W-1:0] : '0;

endmodule

FILE: rtl/wash_cycle_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wash_cycle_sequencer_unit
// Timed wash-cycle sequencer: one tick or command per item, one result each.
// ----------------------------------------------------------------------------
//  Channel   Handshake           Payload
//  input     i_valid / o_stall   i_opcode, i_cold_mode, i_level_reached
//  result    o_valid / i_stall   o_phase, five actuator bits, o_remaining_ms
//  config    i_cfg_we            i_cfg_addr, i_cfg_wdata
//
//  One item per cycle unless o_stall holds the input; a result is shown once its item
//  has passed the input register, then the step logic into the result register.
//  Synchronous active-low reset clears phase, timer, actuators and valids
//  and loads the default timings.
//  A stalled result holds the input register; the input stalls only while
//  both registers are full and the result is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wash_cycle_sequencer_unit #(
    parameter int TIMER_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [wcs_pkg::OP_W-1:0]      i_opcode,
    input  logic                          i_cold_mode,
    input  logic                          i_level_reached,
    // result items
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [wcs_pkg::PH_W-1:0]      o_phase,
    output logic                          o_vacuum_pump_on,
    output logic                          o_milk_pump_on,
    output logic                          o_cold_valve_on,
    output logic                          o_hot_valve_on,
    output logic                          o_divert_valve_on,
    output logic [wcs_pkg::CFG_W-1:0]     o_remaining_ms,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [wcs_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [wcs_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import wcs_pkg::*;

    // Input register
    logic                  r_in_valid;
    logic [OP_W-1:0]       r_opcode;
    logic                  r_cold_mode;
    logic                  r_level;

    // Sequencer state
    logic [PH_W-1:0]       r_phase;
    logic [TIMER_BITS-1:0] r_elapsed;
    logic                  r_cold_choice;
    t_act                  r_act;
    t_cfg                  r_cfg;

    // Result register
    logic                  r_out_valid;
    logic [PH_W-1:0]       r_out_phase;
    t_act                  r_out_act;
    logic [CFG_W-1:0]      r_out_rem;

    // Next values
    logic [PH_W-1:0]       n_phase;
    logic [TIMER_BITS-1:0] n_elapsed;
    logic                  n_cold_choice;
    t_act                  n_act;
    logic [CFG_W-1:0]      n_remaining;

    logic                  w_advance;
    logic                  w_fire;

    // Check helpers
    logic                  w_timed_out;
    logic                  w_enter_timed;

    // Flow control
    assign w_advance = !r_out_valid || !i_stall;
    assign w_fire    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;

    // Step logic
    wcs_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_opcode        (r_opcode),
        .i_cold_mode     (r_cold_mode),
        .i_level_reached (r_level),
        .i_cfg           (r_cfg),
        .i_phase         (r_phase),
        .i_elapsed       (r_elapsed),
        .i_cold_choice   (r_cold_choice),
        .i_act           (r_act),
        .o_phase         (n_phase),
        .o_elapsed       (n_elapsed),
        .o_cold_choice   (n_cold_choice),
        .o_act           (n_act)
    );

    // Remaining time of the state after the item
    wcs_remain #(
        .TIMER_BITS (TIMER_BITS)
    ) u_remain (
        .i_phase     (n_phase),
        .i_elapsed   (n_elapsed),
        .i_cfg       (r_cfg),
        .o_remaining (n_remaining)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_opcode    <= i_opcode;
            r_cold_mode <= i_cold_mode;
            r_level     <= i_level_reached;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_WAIT;
            r_elapsed     <= '0;
            r_cold_choice <= 1'b0;
            r_act         <= '0;
        end else if (w_fire) begin
            r_phase       <= n_phase;
            r_elapsed     <= n_elapsed;
            r_cold_choice <= n_cold_choice;
            r_act         <= n_act;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_delay_ms    <= RST_SETTLE;
            r_cfg.milk_pump_delay_ms <= RST_MILK;
            r_cfg.clean_time_ms      <= RST_CLEAN;
            r_cfg.drain_time_ms      <= RST_DRAIN;
            r_cfg.purge_time_ms      <= RST_PURGE;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SETTLE: r_cfg.settle_delay_ms    <= i_cfg_wdata;
                CFG_MILK:   r_cfg.milk_pump_delay_ms <= i_cfg_wdata;
                CFG_CLEAN:  r_cfg.clean_time_ms      <= i_cfg_wdata;
                CFG_DRAIN:  r_cfg.drain_time_ms      <= i_cfg_wdata;
                CFG_PURGE:  r_cfg.purge_time_ms      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_phase <= n_phase;
            r_out_act   <= n_act;
            r_out_rem   <= n_remaining;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_phase           = r_out_phase;
    assign o_vacuum_pump_on  = r_out_act.vacuum;
    assign o_milk_pump_on    = r_out_act.milk;
    assign o_cold_valve_on   = r_out_act.cold;
    assign o_hot_valve_on    = r_out_act.hot;
    assign o_divert_valve_on = r_out_act.divert;
    assign o_remaining_ms    = r_out_rem;

    // Timed phases of the shown result and of the phase being entered
    assign w_timed_out   = (r_out_phase == PH_CLEAN) || (r_out_phase == PH_DRAIN)
                           || (r_out_phase == PH_PURGE);
    assign w_enter_timed = w_fire && (n_phase != r_phase)
                           && ((n_phase == PH_CLEAN) || (n_phase == PH_DRAIN)
                               || (n_phase == PH_PURGE));

    // Checks
    `ASSERT_IMPL(a_phase_legal, 1'b1, r_phase <= PH_DONE)
    `ASSERT_IMPL(a_rem_only_timed, r_out_valid && (r_out_rem != '0), w_timed_out)
    `ASSERT_NEXT(a_enter_clears_timer, w_enter_timed, r_elapsed == '0)
    `ASSERT_NEXT(a_held_item_kept, r_in_valid && !w_advance, r_in_valid)

endmodule

FILE: tb/wash_cycle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wash_cycle_checker
// Watches both item channels and the timing register port of the wash-cycle
// sequencer, predicts the status item for every accepted input item and
// compares the status items that come out, in order and field by field.
// ----------------------------------------------------------------------------
module wash_cycle_checker #(
    parameter int TIMER_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    input  logic                          o_stall,
    input  logic [wcs_pkg::OP_W-1:0]      i_opcode,
    input  logic                          i_cold_mode,
    input  logic                          i_level_reached,
    // result channel
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [wcs_pkg::PH_W-1:0]      o_phase,
    input  logic                          o_vacuum_pump_on,
    input  logic                          o_milk_pump_on,
    input  logic                          o_cold_valve_on,
    input  logic                          o_hot_valve_on,
    input  logic                          o_divert_valve_on,
    input  logic [wcs_pkg::CFG_W-1:0]     o_remaining_ms,
    // timing register writes
    input  logic                          i_cfg_we,
    input  logic [wcs_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [wcs_pkg::CFG_W-1:0]     i_cfg_wdata,
    // status toward the testbench top
    output int                            o_open_items,
    output int                            o_mismatches
);
    import wcs_pkg::*;

    typedef struct packed {
        logic [PH_W-1:0]  phase;
        t_act             act;
        logic [CFG_W-1:0] remaining;
    } t_status;

    localparam logic [TIMER_BITS-1:0] ELAPSED_MAX = '1;

    // Shadow of the sequencer state and its timing registers
    t_cfg                  timing;
    logic [PH_W-1:0]       phase_q;
    logic [TIMER_BITS-1:0] elapsed_q;
    logic                  cold_sel;
    t_act                  act_q;

    t_status               expected_status_q[$];
    t_status               seen_status;
    t_status               want_status;
    int                    mismatches = 0;

    function automatic void enter_phase(input logic [PH_W-1:0] next);
        elapsed_q = '0;
        phase_q   = next;
    endfunction

    // Phase time minus elapsed, zero once elapsed has caught up
    function automatic logic [CFG_W-1:0] time_left(input logic [CFG_W-1:0] limit);
        logic [63:0] spent;
        spent = 64'(elapsed_q);
        if (spent >= 64'(limit)) begin
            return '0;
        end
        return limit - spent[CFG_W-1:0];
    endfunction

    // One millisecond: bump the saturating timer, then the phase action
    function automatic void run_tick(input logic level);
        logic [63:0] el;
        if (elapsed_q != ELAPSED_MAX) begin
            elapsed_q = elapsed_q + TIMER_BITS'(1);
        end
        el = 64'(elapsed_q);
        case (phase_q)
            PH_FILL: begin
                act_q.divert = 1'b1;
                if (cold_sel) begin
                    act_q.cold = 1'b1;
                end else begin
                    act_q.hot = 1'b1;
                end
                if (level) begin
                    act_q.cold = 1'b0;
                    act_q.hot  = 1'b0;
                    enter_phase(PH_SETTLE);
                end
            end
            PH_PAUSED: begin
                act_q.cold = 1'b0;
                act_q.hot  = 1'b0;
            end
            PH_SETTLE: begin
                if (el > 64'(timing.settle_delay_ms)) enter_phase(PH_CLEAN);
            end
            PH_CLEAN: begin
                act_q.vacuum = 1'b1;
                if (el > 64'(timing.milk_pump_delay_ms)) act_q.milk = 1'b1;
                if (el > 64'(timing.clean_time_ms)) enter_phase(PH_DRAIN);
            end
            PH_DRAIN: begin
                act_q.milk   = 1'b0;
                act_q.divert = 1'b0;
                if (el > 64'(timing.drain_time_ms)) enter_phase(PH_PURGE);
            end
            PH_PURGE: begin
                act_q.milk = 1'b1;
                if (el > 64'(timing.purge_time_ms)) begin
                    act_q.milk = 1'b0;
                    enter_phase(PH_SETTLE2);
                end
            end
            PH_SETTLE2: begin
                if (el > 64'(timing.settle_delay_ms)) begin
                    act_q.vacuum = 1'b0;
                    enter_phase(PH_FINAL);
                end
            end
            PH_FINAL: begin
                if (el > 64'(timing.settle_delay_ms)) phase_q = PH_DONE;
            end
            default: ;
        endcase
    endfunction

    // Apply one item and return the status it should produce
    function automatic t_status step_sequencer(input logic [OP_W-1:0] op,
                                               input logic cold,
                                               input logic level);
        t_status s;
        case (op)
            OP_TICK:       run_tick(level);
            OP_START: begin
                cold_sel = cold;
                phase_q  = PH_FILL;
            end
            OP_PAUSE:      if (phase_q == PH_FILL) phase_q = PH_PAUSED;
            OP_RESUME:     if (phase_q == PH_PAUSED) phase_q = PH_FILL;
            OP_RESET_DONE: if (phase_q == PH_DONE) phase_q = PH_WAIT;
            default: ;
        endcase
        s.phase = phase_q;
        s.act   = act_q;
        case (phase_q)
            PH_CLEAN: s.remaining = time_left(timing.clean_time_ms);
            PH_DRAIN: s.remaining = time_left(timing.drain_time_ms);
            PH_PURGE: s.remaining = time_left(timing.purge_time_ms);
            default:  s.remaining = '0;
        endcase
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timing.settle_delay_ms    = RST_SETTLE;
            timing.milk_pump_delay_ms = RST_MILK;
            timing.clean_time_ms      = RST_CLEAN;
            timing.drain_time_ms      = RST_DRAIN;
            timing.purge_time_ms      = RST_PURGE;
            phase_q   = PH_WAIT;
            elapsed_q = '0;
            cold_sel  = 1'b0;
            act_q     = '0;
            expected_status_q.delete();
        end else begin
            // timing register writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SETTLE: timing.settle_delay_ms    = i_cfg_wdata;
                    CFG_MILK:   timing.milk_pump_delay_ms = i_cfg_wdata;
                    CFG_CLEAN:  timing.clean_time_ms      = i_cfg_wdata;
                    CFG_DRAIN:  timing.drain_time_ms      = i_cfg_wdata;
                    CFG_PURGE:  timing.purge_time_ms      = i_cfg_wdata;
                    default: ;
                endcase
            end

            // accepted input item
            if (i_valid && !o_stall) begin
                expected_status_q.push_back(
                    step_sequencer(i_opcode, i_cold_mode, i_level_reached));
            end

            // accepted status item
            if (o_valid && !i_stall) begin
                seen_status.phase      = o_phase;
                seen_status.act.vacuum = o_vacuum_pump_on;
                seen_status.act.milk   = o_milk_pump_on;
                seen_status.act.cold   = o_cold_valve_on;
                seen_status.act.hot    = o_hot_valve_on;
                seen_status.act.divert = o_divert_valve_on;
                seen_status.remaining  = o_remaining_ms;
                if (expected_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: status item with none expected: phase %0d", $realtime,
                                 o_phase);
                    end
                end else begin
                    want_status = expected_status_q.pop_front();
                    if (seen_status !== want_status) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp/got phase %0d/%0d vac %b/%b milk %b/%b",
                                     $realtime, want_status.phase, seen_status.phase,
                                     want_status.act.vacuum, seen_status.act.vacuum,
                                     want_status.act.milk, seen_status.act.milk);
                            $display("    cold %b/%b hot %b/%b divert %b/%b remaining %0d/%0d",
                                     want_status.act.cold, seen_status.act.cold,
                                     want_status.act.hot, seen_status.act.hot,
                                     want_status.act.divert, seen_status.act.divert,
                                     want_status.remaining, seen_status.remaining);
                        end
                    end
                end
            end
        end
        o_open_items <= expected_status_q.size();
        o_mismatches <= mismatches;
    end

endmodule

FILE: tb/wash_cycle_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wash_cycle_sequencer_unit_tb
// Drives ticks and commands into the wash-cycle sequencer: a directed walk
// through commands in the wait, fill, pause and done phases, then random wash cycles under
// changing timings and idling.
// The checker beside the block predicts and compares every status item.
// ----------------------------------------------------------------------------
module wash_cycle_sequencer_unit_tb;
    import wcs_pkg::*;

    // Timer narrower than the timing registers: the top timing never ends
    localparam int TIMER_W      = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1400;

    // Opcodes the block must ignore
    localparam logic [OP_W-1:0]  OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0]  OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0]  OP_SPARE_7 = 3'd7;

    localparam logic [CFG_W-1:0] CFG_TOP   = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [OP_W-1:0]       i_opcode;
    logic                  i_cold_mode;
    logic                  i_level_reached;
    logic                  o_valid;
    logic                  i_stall;
    logic [PH_W-1:0]       o_phase;
    logic                  o_vacuum_pump_on;
    logic                  o_milk_pump_on;
    logic                  o_cold_valve_on;
    logic                  o_hot_valve_on;
    logic                  o_divert_valve_on;
    logic [CFG_W-1:0]      o_remaining_ms;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;

    int   open_items;
    int   mismatches;
    int   cycle_cnt = 0;
    int   send_gap_pct;
    int   stall_pct;
    int   items_sent;
    t_cfg timing_now;

    // Idling per random phase: none, sender only, receiver only, both
    int   gap_pct_of[4]   = '{0, 70, 0, 27};
    int   stall_pct_of[4] = '{0, 0, 70, 27};

    always #2 i_clk = ~i_clk;

    wash_cycle_sequencer_unit #(
        .TIMER_BITS (TIMER_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_cold_mode       (i_cold_mode),
        .i_level_reached   (i_level_reached),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_phase           (o_phase),
        .o_vacuum_pump_on  (o_vacuum_pump_on),
        .o_milk_pump_on    (o_milk_pump_on),
        .o_cold_valve_on   (o_cold_valve_on),
        .o_hot_valve_on    (o_hot_valve_on),
        .o_divert_valve_on (o_divert_valve_on),
        .o_remaining_ms    (o_remaining_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    wash_cycle_checker #(
        .TIMER_BITS (TIMER_W)
    ) result_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_cold_mode       (i_cold_mode),
        .i_level_reached   (i_level_reached),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_phase           (o_phase),
        .o_vacuum_pump_on  (o_vacuum_pump_on),
        .o_milk_pump_on    (o_milk_pump_on),
        .o_cold_valve_on   (o_cold_valve_on),
        .o_hot_valve_on    (o_hot_valve_on),
        .o_divert_valve_on (o_divert_valve_on),
        .o_remaining_ms    (o_remaining_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_open_items      (open_items),
        .o_mismatches      (mismatches)
    );

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic push_item(input logic [OP_W-1:0] op, input logic cold,
                             input logic level);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_cold_mode     <= cold;
        i_level_reached <= level;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic push_noise();
        push_item(OP_W'($urandom_range(0, 7)), rand_bit(), rand_bit());
    endtask

    // Stop sending and wait until every status item is back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (open_items != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_timings(input t_cfg t);
        write_reg(CFG_SETTLE, t.settle_delay_ms);
        write_reg(CFG_MILK, t.milk_pump_delay_ms);
        write_reg(CFG_CLEAN, t.clean_time_ms);
        write_reg(CFG_DRAIN, t.drain_time_ms);
        write_reg(CFG_PURGE, t.purge_time_ms);
        i_cfg_we   <= 1'b0;
        timing_now  = t;
    endtask

    // Mostly small timings so cycles complete; now and then the top value
    function automatic logic [CFG_W-1:0] rand_timing(input int hi);
        if ($urandom_range(0, 7) == 0) begin
            return CFG_TOP;
        end
        return CFG_W'($urandom_range(0, hi));
    endfunction

    // Start, fill (maybe paused), level reached, then ticks through the cycle
    task automatic run_wash_cycle();
        int     run_ticks;
        int     k;
        longint span;
        push_item(OP_START, rand_bit(), rand_bit());
        repeat ($urandom_range(0, 3)) push_item(OP_TICK, rand_bit(), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            push_item(OP_PAUSE, rand_bit(), rand_bit());
            repeat ($urandom_range(0, 2)) begin
                push_item(OP_TICK, rand_bit(), rand_bit());
            end
            if ($urandom_range(0, 4) != 0) begin
                push_item(OP_RESUME, rand_bit(), rand_bit());
            end
        end
        push_item(OP_TICK, rand_bit(), 1'b1);
        span = longint'(timing_now.settle_delay_ms);
        span = 3 * span + longint'(timing_now.clean_time_ms)
               + longint'(timing_now.drain_time_ms)
               + longint'(timing_now.purge_time_ms) + 8;
        run_ticks = (span > 90) ? 90 : int'(span);
        // sometimes cut the cycle short
        if ($urandom_range(0, 4) == 0) run_ticks = $urandom_range(0, run_ticks);
        for (k = 0; k < run_ticks; k++) begin
            if ($urandom_range(0, 11) == 0) push_noise();
            push_item(OP_TICK, rand_bit(), rand_bit());
        end
        push_item(OP_RESET_DONE, rand_bit(), rand_bit());
    endtask

    initial begin
        int   mode;
        int   part;
        int   goal;
        t_cfg t;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_opcode        = OP_TICK;
        i_cold_mode     = 1'b0;
        i_level_reached = 1'b0;
        i_stall         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = CFG_SETTLE;
        i_cfg_wdata     = '0;
        send_gap_pct    = 0;
        stall_pct       = 0;
        items_sent      = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Commands that do nothing while waiting, spare opcodes included
        push_item(OP_RESET_DONE, 1'b1, 1'b1);
        push_item(OP_PAUSE, 1'b0, 1'b0);
        push_item(OP_RESUME, 1'b1, 1'b0);
        push_item(OP_SPARE_5, 1'b1, 1'b1);
        push_item(OP_SPARE_6, 1'b0, 1'b1);
        push_item(OP_SPARE_7, 1'b1, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b1);
        // Cold fill, pause closes valves, resume reopens
        push_item(OP_START, 1'b1, 1'b0);
        push_item(OP_TICK, 1'b0, 1'b0);
        push_item(OP_PAUSE, 1'b0, 1'b0);
        push_item(OP_TICK, 1'b0, 1'b1);
        push_item(OP_PAUSE, 1'b1, 1'b1);
        push_item(OP_RESUME, 1'b0, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b0);
        // Restart during fill selects hot, leaving the cold valve open too; level reached ends the fill
        push_item(OP_START, 1'b0, 1'b1);
        push_item(OP_TICK, 1'b0, 1'b0);
        push_item(OP_TICK, 1'b0, 1'b1);
        push_item(OP_RESET_DONE, 1'b0, 1'b0);
        push_item(OP_TICK, 1'b1, 1'b1);

        // All timings at zero: one tick per timed phase through to done
        drain_results();
        load_timings('0);
        repeat (6) push_item(OP_TICK, 1'b0, 1'b0);
        push_item(OP_RESET_DONE, 1'b1, 1'b0);

        // Random wash cycles under each idling pattern and fresh timings
        for (mode = 0; mode < 4; mode++) begin
            for (part = 0; part < 2; part++) begin
                drain_results();
                t.settle_delay_ms    = rand_timing(5);
                t.milk_pump_delay_ms = rand_timing(12);
                t.clean_time_ms      = rand_timing(20);
                t.drain_time_ms      = rand_timing(8);
                t.purge_time_ms      = rand_timing(8);
                load_timings(t);
                send_gap_pct = gap_pct_of[mode];
                stall_pct   <= stall_pct_of[mode];
                goal = items_sent + RANDOM_ITEMS / 8;
                while (items_sent < goal) run_wash_cycle();
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
